// ----- rtl/pse_pkg.sv -----
`timescale 1ns / 1ps

package pse_pkg;

  // Operand stack geometry.
  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  // Token queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Divider: one quotient bit per cycle over a 48-bit Q16.16 dividend.
  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Token operation codes.
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // Error codes reported with each result.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;

  // Saturation limits of signed Q16.16.
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Token class decided by the front.
  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_ARITH,
    KIND_NOP
  } kind_e;

  // Input item as it arrives on the port.
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  // Result item as it leaves the port.
  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         error;
  } out_item_t;

  // Classified token held in the queue.
  typedef struct packed {
    kind_e              kind;
    logic [2:0]         op;
    logic signed [31:0] value;
    logic               last;
  } cmd_t;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic signed [31:0] dividend;
    logic signed [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/pse_front.sv -----
`timescale 1ns / 1ps

module pse_front
  import pse_pkg::*;
(
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     queue_full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  // The front takes a token whenever the queue has room.
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Sort each token into push, arithmetic or no-operation.
  always_comb begin
    cmd_o.op    = in_item_i.operation;
    cmd_o.value = in_item_i.value;
    cmd_o.last  = in_item_i.last;
    if (in_item_i.operation == OP_PUSH) begin
      cmd_o.kind = KIND_PUSH;
    end else if (in_item_i.operation inside {[OP_ADD:OP_DIV]}) begin
      cmd_o.kind = KIND_ARITH;
    end else begin
      cmd_o.kind = KIND_NOP;
    end
  end

endmodule

// ----- rtl/pse_cmd_queue.sv -----
`timescale 1ns / 1ps

module pse_cmd_queue
  import pse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q;
  logic [QCNT_W-1:0] cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Token storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never goes past the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("token queue count out of range");
`endif

endmodule

// ----- rtl/pse_divider.sv -----
`timescale 1ns / 1ps

module pse_divider
  import pse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [31:0]          rem_q;
  logic [47:0]          quo_q;
  logic [31:0]          dvs_q;
  logic                 neg_q;
  logic [32:0]          trial;
  logic                 fits;
  logic [31:0]          dividend_mag;
  logic [31:0]          divisor_mag;
  logic [47:0]          quo_neg;

  // Operand magnitudes; the most negative number maps to 2^31.
  assign dividend_mag = req_i.dividend[31] ? 32'(-req_i.dividend) : 32'(req_i.dividend);
  assign divisor_mag  = req_i.divisor[31] ? 32'(-req_i.divisor) : 32'(req_i.divisor);

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign trial = {rem_q, quo_q[47]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + DIV_CNT_W'(1);
      end
    end
  end

  // Remainder and quotient datapath.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= {dividend_mag, 16'h0000};
      dvs_q <= divisor_mag;
      neg_q <= req_i.dividend[31] ^ req_i.divisor[31];
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      quo_q <= {quo_q[46:0], fits};
    end
  end

  // Apply the sign and saturate to the Q16.16 range.
  assign quo_neg = -quo_q;

  always_comb begin
    rsp_o.done = done_q;
    if (neg_q) begin
      rsp_o.quotient = (quo_q > 48'h0000_8000_0000) ? Q_MIN : quo_neg[31:0];
    end else begin
      rsp_o.quotient = (quo_q > 48'h0000_7FFF_FFFF) ? Q_MAX : quo_q[31:0];
    end
  end

`ifndef NO_ASSERTIONS
  // A new division starts only when the unit is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  // Completion follows the final step of a running division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a running division");
`endif

endmodule

// ----- rtl/pse_back.sv -----
`timescale 1ns / 1ps

module pse_back
  import pse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      q_head_i,
  output logic      q_pop_o,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_RD_B   = 4'd2;
  localparam logic [3:0] ST_RD_A   = 4'd3;
  localparam logic [3:0] ST_EXEC   = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_DIV    = 4'd6;
  localparam logic [3:0] ST_WRITE  = 4'd7;
  localparam logic [3:0] ST_FINISH = 4'd8;
  localparam logic [3:0] ST_TOP    = 4'd9;
  localparam logic [3:0] ST_EMIT   = 4'd10;

  localparam logic signed [47:0] WIDE_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] WIDE_MIN = 48'shFFFF_8000_0000;

  logic [3:0]         state_q;
  logic [3:0]         state_d;
  cmd_t               cmd_q;
  cmd_t               cmd_d;
  logic [DEPTH_W-1:0] depth_q;
  logic [DEPTH_W-1:0] depth_d;
  logic [1:0]         err_q;
  logic [1:0]         err_d;
  logic signed [31:0] a_q;
  logic signed [31:0] a_d;
  logic signed [31:0] b_q;
  logic signed [31:0] b_d;
  logic signed [31:0] res_q;
  logic signed [31:0] res_d;
  logic signed [63:0] prod_q;
  logic signed [31:0] rd_data_q;
  logic               out_valid_q;
  out_item_t          out_item_q;
  logic [31:0]        stack_mem [STACK_DEPTH];
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [31:0]        wr_data;
  logic               rd_en;
  logic [PTR_W-1:0]   rd_addr;
  logic               out_load;
  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] depth_m2;
  logic signed [32:0] sum;
  logic signed [32:0] diff;

  // Keep the first error of an expression.
  function automatic logic [1:0] keep_err(input logic [1:0] cur, input logic [1:0] code);
    keep_err = (cur == ERR_NONE) ? code : cur;
  endfunction

  // Clamp a wide signed value to the Q16.16 range.
  function automatic logic [31:0] sat_wide(input logic signed [47:0] v);
    if (v > WIDE_MAX) begin
      sat_wide = Q_MAX;
    end else if (v < WIDE_MIN) begin
      sat_wide = Q_MIN;
    end else begin
      sat_wide = v[31:0];
    end
  endfunction

  assign depth_m1 = depth_q - DEPTH_W'(1);
  assign depth_m2 = depth_q - DEPTH_W'(2);
  assign sum      = {a_q[31], a_q} + {b_q[31], b_q};
  assign diff     = {a_q[31], a_q} - {b_q[31], b_q};

  // Token sequencer: read operands, compute, write back, emit on the last token.
  always_comb begin
    state_d            = state_q;
    cmd_d              = cmd_q;
    depth_d            = depth_q;
    err_d              = err_q;
    a_d                = a_q;
    b_d                = b_q;
    res_d              = res_q;
    q_pop_o            = 1'b0;
    wr_en              = 1'b0;
    wr_addr            = depth_m2[PTR_W-1:0];
    wr_data            = res_q;
    rd_en              = 1'b0;
    rd_addr            = depth_m1[PTR_W-1:0];
    div_req_o.start    = 1'b0;
    div_req_o.dividend = a_q;
    div_req_o.divisor  = b_q;
    out_load           = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          cmd_d   = q_head_i;
          q_pop_o = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FINISH;
        case (cmd_q.kind)
          KIND_PUSH: begin
            if (depth_q < DEPTH_W'(STACK_DEPTH)) begin
              wr_en   = 1'b1;
              wr_addr = depth_q[PTR_W-1:0];
              wr_data = cmd_q.value;
              depth_d = depth_q + DEPTH_W'(1);
            end else begin
              err_d = keep_err(err_q, ERR_OVER);
            end
          end
          KIND_ARITH: begin
            if (depth_q < DEPTH_W'(2)) begin
              err_d = keep_err(err_q, ERR_UNDER);
            end else begin
              rd_en   = 1'b1;
              state_d = ST_RD_B;
            end
          end
          default: begin
          end
        endcase
      end
      ST_RD_B: begin
        b_d     = rd_data_q;
        rd_en   = 1'b1;
        rd_addr = depth_m2[PTR_W-1:0];
        state_d = ST_RD_A;
      end
      ST_RD_A: begin
        a_d     = rd_data_q;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (cmd_q.op)
          OP_ADD: begin
            res_d   = sat_wide(48'(sum));
            state_d = ST_WRITE;
          end
          OP_SUB: begin
            res_d   = sat_wide(48'(diff));
            state_d = ST_WRITE;
          end
          OP_MUL: begin
            state_d = ST_MUL;
          end
          default: begin
            if (b_q == '0) begin
              err_d   = keep_err(err_q, ERR_DIVZ);
              res_d   = '0;
              state_d = ST_WRITE;
            end else begin
              div_req_o.start = 1'b1;
              state_d         = ST_DIV;
            end
          end
        endcase
      end
      ST_MUL: begin
        // Arithmetic shift of the product rounds toward minus infinity.
        res_d   = sat_wide(prod_q[63:16]);
        state_d = ST_WRITE;
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          res_d   = div_rsp_i.quotient;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        wr_en   = 1'b1;
        depth_d = depth_m1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!cmd_q.last) begin
          state_d = ST_IDLE;
        end else if (depth_q == '0) begin
          res_d   = '0;
          err_d   = keep_err(err_q, ERR_UNDER);
          state_d = ST_EMIT;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_TOP;
        end
      end
      ST_TOP: begin
        res_d   = rd_data_q;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          depth_d  = '0;
          err_d    = ERR_NONE;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      err_q   <= err_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    prod_q <= a_q * b_q;
    if (out_load) begin
      out_item_q.result <= res_q;
      out_item_q.error  <= err_q;
    end
  end

  // Operand stack memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  // The stack never holds more entries than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth out of range");

  // An operator writes back only when two operands were on the stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> depth_q >= DEPTH_W'(2))
    else $error("write back with fewer than two operands");

  // Emitting a result leaves a clean stack and error for the next expression.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> depth_q == '0 && err_q == ERR_NONE && out_valid_q)
    else $error("expression state not cleared after result");
`endif

endmodule

// ----- rtl/postfix_stack_evaluator.sv -----
// Postfix evaluator for signed Q16.16 tokens. Each accepted token goes into a
// two-entry queue, so the input side keeps taking tokens while the queue has room,
// also while the evaluator works and while a finished result waits in the output
// register. The back end keeps the operand stack in a single-port memory and handles
// one token at a time. Divide waits on the divider, which makes one quotient bit
// per cycle over 48 steps. A token marked last then reads the top of the stack and
// loads the result register. The error field holds the first error of the expression;
// stack and error clear after each result.
`timescale 1ns / 1ps

module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic     queue_full;
  logic     queue_push;
  cmd_t     front_cmd;
  logic     queue_pop;
  logic     queue_valid;
  cmd_t     queue_head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Front end: token intake and classification.
  pse_front u_front (
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .queue_full_i (queue_full),
    .push_o       (queue_push),
    .cmd_o        (front_cmd)
  );

  // Queue that decouples intake from evaluation.
  pse_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .head_o  (queue_head)
  );

  // Back end: operand stack, arithmetic and result register.
  pse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (queue_valid),
    .q_head_i    (queue_head),
    .q_pop_o     (queue_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Iterative Q16.16 divider.
  pse_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule
